/* sv/positional_list_insert_delete_macros.svh */
// Assertion macros for the positional list checker.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, sampled on clk, idle in reset.
`define PLID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list assertion failed");

// Next-cycle implication, sampled on clk, idle in reset.
`define PLID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list assertion failed");

`endif

/* sv/plid_pkg.sv */
// Shared types and codes for the positional list block.
package plid_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_DUMP   = 2'd2,
		MODE_RSVD   = 2'd3
	} plid_mode_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_RSVD   = 2'd3
	} plid_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_DUMP
	} plid_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // transaction accepted: apply the operation
		logic rotate;    // dump entry taken: rotate the chain by one
		logic show_dump; // drive the head cell onto the result port
	} plid_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic dump_go;   // dump requested on a non-empty list
		logic dump_last; // head cell is the final dump entry
	} plid_sts_t;

endpackage

/* sv/plid_ctrl.sv */
// Controller state machine for the positional list block.
module plid_ctrl import plid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  plid_sts_t sts,
	output plid_cmd_t cmd
);

	plid_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.dump_go ? ST_DUMP : ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (out_ready && sts.dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd.load      = 1'b0;
		cmd.rotate    = 1'b0;
		cmd.show_dump = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RESP: begin
				out_valid = 1'b1;
			end
			ST_DUMP: begin
				out_valid     = 1'b1;
				cmd.show_dump = 1'b1;
				cmd.rotate    = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* sv/plid_dp.sv */
// Datapath for the positional list block: shifting cell chain, count and result register.
module plid_dp import plid_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  plid_cmd_t          cmd,
	output plid_sts_t          sts,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	output logic signed [31:0] item_value,
	output logic               item_valid,
	output logic [1:0]         status,
	output logic [5:0]         element_count,
	output logic               last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 6) ? CW : 6) + 1;
	localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

	logic signed [31:0] cell_q [CAPACITY];
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rem_q;
	plid_status_t       res_status_q;

	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          ins_ok;
	logic          del_ok;
	plid_mode_t    op;
	plid_status_t  op_status;

	assign op    = plid_mode_t'(mode);
	assign pos_x = XW'(position);
	assign cnt_x = XW'(count_q);

	assign ins_ok = cmd.load && (op == MODE_INSERT) && (pos_x != '0)
		&& (pos_x <= cnt_x + XW'(1)) && (cnt_x < CAP_X);
	assign del_ok = cmd.load && (op == MODE_DELETE) && (pos_x != '0)
		&& (pos_x <= cnt_x);

	always_comb begin
		op_status = STAT_OK;
		case (op)
			MODE_INSERT: begin
				if ((pos_x == '0) || (pos_x > cnt_x + XW'(1))) begin
					op_status = STAT_BADPOS;
				end else if (cnt_x >= CAP_X) begin
					op_status = STAT_FULL;
				end
			end
			MODE_DELETE: begin
				if ((pos_x == '0) || (pos_x > cnt_x)) begin
					op_status = STAT_BADPOS;
				end
			end
			MODE_DUMP:   op_status = STAT_OK;
			default:     op_status = STAT_BADPOS;
		endcase
	end

	// Each cell looks only at itself, its neighbours and the head cell.
	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		localparam int PREV = (gi == 0) ? 0 : gi - 1;
		localparam int NEXT = (gi == CAPACITY - 1) ? gi : gi + 1;
		localparam logic [XW-1:0] PLACE = XW'(gi + 1);

		logic signed [31:0] cell_d;

		always_comb begin
			cell_d = cell_q[gi];
			if (ins_ok) begin
				if (PLACE == pos_x) begin
					cell_d = value;
				end else if (PLACE > pos_x) begin
					cell_d = cell_q[PREV];
				end
			end else if (del_ok) begin
				if (PLACE >= pos_x) begin
					cell_d = cell_q[NEXT];
				end
			end else if (cmd.rotate) begin
				// wrap the head round to the tail so the list is whole after the dump
				if (PLACE < cnt_x) begin
					cell_d = cell_q[NEXT];
				end else if (PLACE == cnt_x) begin
					cell_d = cell_q[0];
				end
			end
		end

		always_ff @(posedge clk) begin
			cell_q[gi] <= cell_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (ins_ok) begin
				count_q <= count_q + CW'(1);
			end else if (del_ok) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load) begin
				rem_q <= count_q;
			end else if (cmd.rotate) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= op_status;
		end
	end

	assign sts.dump_go   = (op == MODE_DUMP) && (count_q != '0);
	assign sts.dump_last = (rem_q == CW'(1));

	always_comb begin
		element_count = 6'(count_q);
		if (cmd.show_dump) begin
			item_value = cell_q[0];
			item_valid = 1'b1;
			status     = STAT_OK;
			last       = sts.dump_last;
		end else begin
			item_value = '0;
			item_valid = 1'b0;
			status     = res_status_q;
			last       = 1'b1;
		end
	end

endmodule

/* sv/positional_list_insert_delete.sv */
// An insert, delete or rejected transaction shows its result in the cycle after acceptance.
// A dump gives one result per entry, or one result when the list is empty.
// Only one transaction at a time; the next can be taken in the cycle after the last result leaves.
// Insert and delete shift the whole cell chain at once; a dump rotates it once per entry.
// Reset (arst_n low, asynchronous) empties the list and returns the controller to idle.
module positional_list_insert_delete import plid_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] item_value,
	output logic               item_valid,
	output logic [1:0]         status,
	output logic [5:0]         element_count,
	output logic               last
);

	plid_cmd_t cmd;
	plid_sts_t sts;

	plid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	plid_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.value         (value),
		.position      (position),
		.item_value    (item_value),
		.item_valid    (item_valid),
		.status        (status),
		.element_count (element_count),
		.last          (last)
	);

endmodule

/* sv/plid_checker.sv */
// Port-level assertions for the positional list block, bound to the top level.
`include "positional_list_insert_delete_macros.svh"

module plid_checker import plid_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] item_value,
	input logic               item_valid,
	input logic [1:0]         status,
	input logic               last
);

	// One transaction in flight: never take input while a result is shown.
	`PLID_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready)

	// A dump keeps going until its final entry has been taken.
	`PLID_ASSERT_NEXT(a_dump_continues, out_valid && out_ready && !last, out_valid && !in_ready)

	// A real list entry only ever comes with an ok status.
	`PLID_ASSERT_NOW(a_entry_ok, out_valid && item_valid, status == STAT_OK)

	// Hold the result while the sink stalls.
	`PLID_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(item_value))

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the positional list: random and directed insert, delete and dump.
`timescale 1ns / 1ps

module testbench;
	import plid_pkg::*;

	localparam int CAPACITY    = 32;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		plid_mode_t        mode;
		logic signed [31:0] value;
		logic [5:0]        position;
	} list_op_t;

	typedef struct {
		logic signed [31:0] item_value;
		logic               item_valid;
		plid_status_t       status;
		logic [5:0]         element_count;
		logic               last;
	} list_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         mode = 2'd0;
	logic signed [31:0] value = 32'sd0;
	logic [5:0]         position = 6'd0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] item_value;
	logic               item_valid;
	logic [1:0]         status;
	logic [5:0]         element_count;
	logic               last;

	list_op_t     op_queue[$];
	list_op_t     next_op;
	list_result_t due_results[$];
	list_result_t got;

	logic signed [31:0] list_copy[CAPACITY];
	int list_len     = 0;
	int plan_len     = 0;
	int peak_len     = 0;
	int full_rejects = 0;

	int ops_sent     = 0;
	int ops_taken    = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int idle_cycles  = 0;
	int send_idle    = 0;
	int recv_idle    = 0;

	positional_list_insert_delete #(.CAPACITY(CAPACITY)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.value         (value),
		.position      (position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.item_value    (item_value),
		.item_valid    (item_valid),
		.status        (status),
		.element_count (element_count),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one operation to the local copy of the list and queue the results it gives.
	function automatic void update_list_copy(input logic [1:0] op_mode,
			input logic signed [31:0] op_value, input logic [5:0] op_pos);
		int p;
		bit dumped;
		list_result_t r;
		p = op_pos;
		dumped = 1'b0;
		r.item_value = 32'sd0;
		r.item_valid = 1'b0;
		r.status = STAT_OK;
		r.last = 1'b1;
		case (plid_mode_t'(op_mode))
			MODE_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					r.status = STAT_BADPOS;
				end else if (list_len >= CAPACITY) begin
					r.status = STAT_FULL;
					full_rejects++;
				end else begin
					for (int i = list_len; i > p - 1; i--)
						list_copy[i] = list_copy[i - 1];
					list_copy[p - 1] = op_value;
					list_len++;
					if (list_len > peak_len)
						peak_len = list_len;
				end
			end
			MODE_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = STAT_BADPOS;
				end else begin
					for (int i = p - 1; i + 1 < list_len; i++)
						list_copy[i] = list_copy[i + 1];
					list_len--;
				end
			end
			MODE_DUMP: begin
				if (list_len > 0) begin
					dumped = 1'b1;
					for (int i = 0; i < list_len; i++) begin
						r.item_value = list_copy[i];
						r.item_valid = 1'b1;
						r.element_count = 6'(list_len);
						r.last = (i + 1 == list_len);
						due_results.push_back(r);
					end
				end
			end
			default: r.status = STAT_BADPOS;
		endcase
		if (!dumped) begin
			r.element_count = 6'(list_len);
			due_results.push_back(r);
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
			mismatches++;
		end
	endtask

	// Queue an operation and track the list length it leaves, to steer later positions.
	task automatic queue_op(input plid_mode_t m, input logic signed [31:0] v, input logic [5:0] p);
		list_op_t op;
		op.mode = m;
		op.value = v;
		op.position = p;
		op_queue.push_back(op);
		if (m == MODE_INSERT && p >= 1 && p <= plan_len + 1 && plan_len < CAPACITY)
			plan_len++;
		else if (m == MODE_DELETE && p >= 1 && p <= plan_len)
			plan_len--;
	endtask

	task automatic queue_random_ops(input int n, input int ins_pct, input int del_pct,
			input int dump_pct);
		int roll;
		plid_mode_t m;
		logic signed [31:0] v;
		logic [5:0] p;
		bit aim;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99, 0);
			if (roll < ins_pct)
				m = MODE_INSERT;
			else if (roll < ins_pct + del_pct)
				m = MODE_DELETE;
			else if (roll < ins_pct + del_pct + dump_pct)
				m = MODE_DUMP;
			else
				m = MODE_RSVD;
			aim = ($urandom_range(99, 0) < 85);
			if (aim && m == MODE_INSERT)
				p = 6'($urandom_range(plan_len + 1, 1));
			else if (aim && m == MODE_DELETE && plan_len > 0)
				p = 6'($urandom_range(plan_len, 1));
			else
				p = 6'($urandom_range(63, 0));
			if ($urandom_range(9, 0) == 0) begin
				case ($urandom_range(3, 0))
					0: v = 32'sh7fffffff;
					1: v = 32'sh80000000;
					2: v = 32'sd0;
					default: v = -32'sd1;
				endcase
			end else begin
				v = $urandom;
			end
			queue_op(m, v, p);
		end
	endtask

	task automatic drain();
		while (op_queue.size() != 0 || ops_taken != ops_sent || due_results.size() != 0)
			@(posedge clk);
	endtask

	// Driver: hold each transaction until taken, then load the next or idle.
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99, 0) >= recv_idle);
			if (!in_valid || ops_taken == ops_sent) begin
				if (op_queue.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
					next_op = op_queue.pop_front();
					in_valid <= 1'b1;
					mode <= next_op.mode;
					value <= next_op.value;
					position <= next_op.position;
					ops_sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check results against the oldest expectation, then record accepted input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$display("%0t ns: result with nothing expected, value %0h count %0d",
						$time, item_value, element_count);
					mismatches++;
				end else begin
					got = due_results.pop_front();
					check_field("item_value", got.item_value, item_value);
					check_field("item_valid", 32'(got.item_valid), 32'(item_valid));
					check_field("status", 32'(got.status), 32'(status));
					check_field("element_count", 32'(got.element_count), 32'(element_count));
					check_field("last", 32'(got.last), 32'(last));
				end
			end
			if (in_valid && in_ready) begin
				update_list_copy(mode, value, position);
				ops_taken++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("[positional_list_insert_delete] ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle = 19;
		recv_idle = 52;

		// Empty list: dump, deletes and inserts outside the valid range.
		queue_op(MODE_DUMP, 32'sd0, 6'd0);
		queue_op(MODE_DELETE, 32'sd0, 6'd1);
		queue_op(MODE_DELETE, 32'sd0, 6'd0);
		queue_op(MODE_INSERT, 32'sd5, 6'd0);
		queue_op(MODE_INSERT, 32'sd5, 6'd2);
		// Build up four entries at first, last and middle positions.
		queue_op(MODE_INSERT, 32'sh7fffffff, 6'd1);
		queue_op(MODE_INSERT, 32'sh80000000, 6'd2);
		queue_op(MODE_INSERT, -32'sd1, 6'd1);
		queue_op(MODE_INSERT, 32'sd0, 6'd2);
		queue_op(MODE_INSERT, 32'sh5a5a5a5a, 6'd63);
		queue_op(MODE_DUMP, 32'sh12345678, 6'd63);
		queue_op(MODE_RSVD, 32'sh12345678, 6'd5);
		queue_op(MODE_DELETE, 32'sd0, 6'd5);
		queue_op(MODE_DELETE, 32'sd0, 6'd4);
		queue_op(MODE_DELETE, 32'sd0, 6'd2);
		queue_op(MODE_DUMP, 32'sd0, 6'd0);
		queue_op(MODE_DELETE, 32'sd0, 6'd1);
		queue_op(MODE_INSERT, 32'sh0f0f0f0f, 6'd33);
		queue_op(MODE_DELETE, 32'sd0, 6'd1);
		queue_op(MODE_DUMP, 32'sd0, 6'd0);
		drain();

		// Fill hard enough to reach a full list, then mix, then empty it out.
		queue_random_ops(60, 85, 5, 7);
		drain();
		send_idle = 52;
		recv_idle = 19;
		queue_random_ops(35, 40, 40, 16);
		drain();
		send_idle = 0;
		recv_idle = 0;
		queue_random_ops(35, 20, 66, 12);
		drain();
		repeat (8) @(posedge clk);

		$display("Ran %0d list operations and checked %0d results under three idling mixes.",
			ops_taken, results_seen);
		$display("List reached %0d of %0d entries; %0d inserts refused as full.",
			peak_len, CAPACITY, full_rejects);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("[positional_list_insert_delete] OK");
		end else begin
			$display("[positional_list_insert_delete] ERROR");
		end
		$finish;
	end

endmodule
